### rtl/ntok_pkg.sv
// ============================================================================
// ntok_pkg
// Shared types and constants for the netlist character tokeniser: result and
// queue entry layouts, token kind codes, error codes and the keyword table.
// ============================================================================
package ntok_pkg;

    // keyword table dimensions
    localparam int NKW    = 7;
    localparam int KW_MAX = 9;

    // queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [4:0] K_IDENT   = 5'd0;
    localparam logic [4:0] K_NUMBER  = 5'd1;
    localparam logic [4:0] K_KW_BASE = 5'd2;
    localparam logic [4:0] K_DOT     = 5'd9;
    localparam logic [4:0] K_COMMA   = 5'd10;
    localparam logic [4:0] K_SEMI    = 5'd11;
    localparam logic [4:0] K_LPAREN  = 5'd12;
    localparam logic [4:0] K_RPAREN  = 5'd13;
    localparam logic [4:0] K_LBRACK  = 5'd14;
    localparam logic [4:0] K_RBRACK  = 5'd15;
    localparam logic [4:0] K_COLON   = 5'd16;
    localparam logic [4:0] K_EQUALS  = 5'd17;
    localparam logic [4:0] K_EOF     = 5'd18;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_UNTERM  = 2'd2;

    // keyword spellings, zero padded, and their lengths
    localparam logic [7:0] KW_TXT [NKW][KW_MAX] = '{
        '{"m", "o", "d", "u", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", "m", "o", "d", "u", "l", "e"},
        '{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "u", "t", "p", "u", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "o", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "i", "r", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "s", "s", "i", "g", "n", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NKW] = '{4'd6, 4'd9, 4'd5, 4'd6, 4'd5, 4'd4, 4'd6};

    // one result item
    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic       cv;
        logic       done;
        logic [1:0] err;
    } t_res;

    // all results caused by one input byte (one or two)
    typedef struct packed {
        t_res first;
        t_res second;
        logic two;
    } t_entry;

endpackage

### rtl/ntok_front.sv
// ============================================================================
// ntok_front
// Lexer front end: holds the scan mode, keyword match mask and length count,
// classifies each byte and pushes the one or two results it causes.
// ============================================================================
module ntok_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_char_in,
    input  logic                i_end_of_stream,
    input  logic                i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output ntok_pkg::t_entry    o_entry
);

    typedef enum logic [10:0] {
        M_IDLE  = 11'b000_0000_0001,
        M_SLASH = 11'b000_0000_0010,
        M_LINEC = 11'b000_0000_0100,
        M_BLOCK = 11'b000_0000_1000,
        M_BSTAR = 11'b000_0001_0000,
        M_NUM   = 11'b000_0010_0000,
        M_IDENT = 11'b000_0100_0000,
        M_ESC   = 11'b000_1000_0000,
        M_EIDX1 = 11'b001_0000_0000,
        M_EIDX2 = 11'b010_0000_0000,
        M_HALT  = 11'b100_0000_0000
    } t_mode;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c inside {"_", "$", "."});
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            ".":     k = ntok_pkg::K_DOT;
            ",":     k = ntok_pkg::K_COMMA;
            ";":     k = ntok_pkg::K_SEMI;
            "(":     k = ntok_pkg::K_LPAREN;
            ")":     k = ntok_pkg::K_RPAREN;
            "[":     k = ntok_pkg::K_LBRACK;
            "]":     k = ntok_pkg::K_RBRACK;
            ":":     k = ntok_pkg::K_COLON;
            "=":     k = ntok_pkg::K_EQUALS;
            default: k = ntok_pkg::K_IDENT;
        endcase
        return k;
    endfunction

    function automatic ntok_pkg::t_res mk_res(input logic [4:0] kind, input logic [7:0] ch,
                                              input logic cv, input logic done,
                                              input logic [1:0] err);
        ntok_pkg::t_res r;
        r.kind = kind;
        r.ch   = ch;
        r.cv   = cv;
        r.done = done;
        r.err  = err;
        return r;
    endfunction

    t_mode            r_mode, n_mode;
    logic [6:0]       r_mask, n_mask;
    logic [3:0]       r_len, n_len;

    logic             acc;
    logic [7:0]       c;
    logic             eos;
    logic [1:0]       n_cnt;
    ntok_pkg::t_res   res0, res1;

    // idle-byte outcome
    t_mode            id_mode;
    ntok_pkg::t_res   id_res;
    logic             id_emit;
    logic             id_start;
    logic [4:0]       pk;

    // keyword tracking
    logic [6:0]       tr_mask;
    logic [3:0]       tr_len;
    logic [6:0]       st_mask;
    logic [4:0]       ik;

    ntok_pkg::t_res   eof_res;
    ntok_pkg::t_res   err_unknown;
    ntok_pkg::t_res   err_unterm;

    assign c       = i_char_in;
    assign eos     = i_end_of_stream;
    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    assign eof_res     = mk_res(ntok_pkg::K_EOF, 8'h00, 1'b0, 1'b1, ntok_pkg::ERR_NONE);
    assign err_unknown = mk_res(ntok_pkg::K_IDENT, 8'h00, 1'b0, 1'b0, ntok_pkg::ERR_UNKNOWN);
    assign err_unterm  = mk_res(ntok_pkg::K_IDENT, 8'h00, 1'b0, 1'b0, ntok_pkg::ERR_UNTERM);

    // how a byte is lexed when no token is open
    always_comb begin
        id_mode  = M_IDLE;
        id_res   = '0;
        id_emit  = 1'b0;
        id_start = 1'b0;
        pk       = punct_kind(c);
        if (is_space(c)) begin
            id_mode = M_IDLE;
        end else if (c == "/") begin
            id_mode = M_SLASH;
        end else if (pk != ntok_pkg::K_IDENT) begin
            id_res  = mk_res(pk, c, 1'b1, 1'b1, ntok_pkg::ERR_NONE);
            id_emit = 1'b1;
        end else if (c == "\\") begin
            id_mode = M_ESC;
            id_res  = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
            id_emit = 1'b1;
        end else if (is_digit(c)) begin
            id_mode = M_NUM;
            id_res  = mk_res(ntok_pkg::K_NUMBER, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
            id_emit = 1'b1;
        end else if (is_alpha(c) || (c == "_")) begin
            id_mode  = M_IDENT;
            id_res   = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
            id_emit  = 1'b1;
            id_start = 1'b1;
        end else begin
            id_mode = M_HALT;
            id_res  = err_unknown;
            id_emit = 1'b1;
        end
    end

    // keyword mask update, continuing and starting a word; final keyword kind
    always_comb begin
        tr_mask = r_mask;
        st_mask = '1;
        ik      = ntok_pkg::K_IDENT;
        for (int k = 0; k < ntok_pkg::NKW; k++) begin
            if ((r_len >= ntok_pkg::KW_LEN[k]) || (ntok_pkg::KW_TXT[k][r_len] != c)) begin
                tr_mask[k] = 1'b0;
            end
            if (ntok_pkg::KW_TXT[k][0] != c) begin
                st_mask[k] = 1'b0;
            end
        end
        for (int k = ntok_pkg::NKW - 1; k >= 0; k--) begin
            if (r_mask[k] && (ntok_pkg::KW_LEN[k] == r_len)) begin
                ik = ntok_pkg::K_KW_BASE + 5'(k);
            end
        end
        tr_len = (r_len == 4'hF) ? r_len : r_len + 4'd1;
    end

    // main scan step
    always_comb begin
        logic       fin;
        logic [4:0] fin_kind;
        fin      = 1'b0;
        fin_kind = ntok_pkg::K_IDENT;
        n_mode   = r_mode;
        n_mask   = r_mask;
        n_len    = r_len;
        n_cnt    = 2'd0;
        res0     = '0;
        res1     = '0;
        case (r_mode)
            M_IDLE: begin
                if (eos) begin
                    res0  = eof_res;
                    n_cnt = 2'd1;
                end else begin
                    res0   = id_res;
                    n_cnt  = {1'b0, id_emit};
                    n_mode = id_mode;
                    if (id_start) begin
                        n_mask = st_mask;
                        n_len  = 4'd1;
                    end
                end
            end
            M_SLASH: begin
                if (!eos && (c == "/")) begin
                    n_mode = M_LINEC;
                end else if (!eos && (c == "*")) begin
                    n_mode = M_BLOCK;
                end else begin
                    n_mode = M_HALT;
                    res0   = err_unknown;
                    n_cnt  = 2'd1;
                end
            end
            M_LINEC: begin
                if (eos) begin
                    n_mode = M_IDLE;
                    res0   = eof_res;
                    n_cnt  = 2'd1;
                end else if (c == 8'h0A) begin
                    n_mode = M_IDLE;
                end
            end
            M_BLOCK, M_BSTAR: begin
                if (eos) begin
                    n_mode = M_HALT;
                    res0   = err_unterm;
                    n_cnt  = 2'd1;
                end else if ((r_mode == M_BSTAR) && (c == "/")) begin
                    n_mode = M_IDLE;
                end else begin
                    n_mode = (c == "*") ? M_BSTAR : M_BLOCK;
                end
            end
            M_NUM: begin
                if (!eos && is_digit(c)) begin
                    res0  = mk_res(ntok_pkg::K_NUMBER, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
                    n_cnt = 2'd1;
                end else begin
                    fin      = 1'b1;
                    fin_kind = ntok_pkg::K_NUMBER;
                end
            end
            M_IDENT: begin
                if (!eos && is_ident_char(c)) begin
                    n_mask = tr_mask;
                    n_len  = tr_len;
                    res0   = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
                    n_cnt  = 2'd1;
                end else begin
                    fin      = 1'b1;
                    fin_kind = ik;
                end
            end
            M_ESC: begin
                if (eos || is_space(c) || (c inside {"]", "(", ")", ".", ";", ",", ":"})) begin
                    fin = 1'b1;
                end else begin
                    if (c == "[") begin
                        n_mode = M_EIDX1;
                    end
                    res0  = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
                    n_cnt = 2'd1;
                end
            end
            M_EIDX1, M_EIDX2: begin
                if (!eos && is_digit(c)) begin
                    res0  = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
                    n_cnt = 2'd1;
                end else if (!eos && (c == ":") && (r_mode == M_EIDX1)) begin
                    n_mode = M_EIDX2;
                    res0   = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b0, ntok_pkg::ERR_NONE);
                    n_cnt  = 2'd1;
                end else if (!eos && (c == "]")) begin
                    n_mode = M_IDLE;
                    res0   = mk_res(ntok_pkg::K_IDENT, c, 1'b1, 1'b1, ntok_pkg::ERR_NONE);
                    n_cnt  = 2'd1;
                end else begin
                    fin = 1'b1;
                end
            end
            M_HALT: begin
                n_mode = M_HALT;
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        // close the open token, then treat the byte as though idle
        if (fin) begin
            res0 = mk_res(fin_kind, 8'h00, 1'b0, 1'b1, ntok_pkg::ERR_NONE);
            if (eos) begin
                n_mode = M_IDLE;
                res1   = eof_res;
                n_cnt  = 2'd2;
            end else begin
                n_mode = id_mode;
                res1   = id_res;
                n_cnt  = id_emit ? 2'd2 : 2'd1;
                if (id_start) begin
                    n_mask = st_mask;
                    n_len  = 4'd1;
                end
            end
        end
    end

    // queue write
    assign o_push         = acc && (n_cnt != 2'd0);
    assign o_entry.first  = res0;
    assign o_entry.second = res1;
    assign o_entry.two    = (n_cnt == 2'd2);

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_mask <= '1;
            r_len  <= '0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_mask <= n_mask;
            r_len  <= n_len;
        end
    end

    // a halted lexer produces nothing
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |-> !o_push)
        else $error("ntok_front: result pushed while halted");

    // a two-result entry always starts with the closing of a token
    a_pair_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.two) |-> (o_entry.first.done && !o_entry.first.cv))
        else $error("ntok_front: pair does not start with a done result");

endmodule

### rtl/ntok_queue.sv
// ============================================================================
// ntok_queue
// Short register queue of result entries between the lexer front end and the
// output back end.
// ============================================================================
module ntok_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ntok_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output ntok_pkg::t_entry    o_entry,
    output logic                o_empty,
    output logic                o_full
);

    ntok_pkg::t_entry               r_mem [ntok_pkg::QDEPTH];
    logic [ntok_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [ntok_pkg::QCNT_W-1:0]    r_count;
    logic                           do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ntok_pkg::QCNT_W'(ntok_pkg::QDEPTH));
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ntok_pkg::QCNT_W'(ntok_pkg::QDEPTH))
        else $error("ntok_queue: fill level beyond depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("ntok_queue: push into a full queue");

endmodule

### rtl/ntok_back.sv
// ============================================================================
// ntok_back
// Output back end: takes queue entries and presents their one or two results
// in turn on the output channel.
// ============================================================================
module ntok_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  ntok_pkg::t_entry    i_entry,
    output logic                o_pop,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [4:0]          o_kind,
    output logic [7:0]          o_lexeme_char,
    output logic                o_char_valid,
    output logic                o_token_done,
    output logic [1:0]          o_error
);

    logic               r_busy;
    logic               r_second;
    ntok_pkg::t_entry   r_ent;
    ntok_pkg::t_res     cur;
    logic               take, last;

    assign cur     = r_second ? r_ent.second : r_ent.first;
    assign last    = !r_ent.two || r_second;
    assign take    = r_busy && i_ready;
    assign o_pop   = !i_empty && (!r_busy || (take && last));
    assign o_valid = r_busy;

    assign o_kind        = cur.kind;
    assign o_lexeme_char = cur.ch;
    assign o_char_valid  = cur.cv;
    assign o_token_done  = cur.done;
    assign o_error       = cur.err;

    // held entry
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    // output sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_busy   <= 1'b1;
            r_second <= 1'b0;
        end else if (take) begin
            r_busy   <= !last;
            r_second <= !last;
        end
    end

    a_second_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_busy && r_ent.two))
        else $error("ntok_back: second result selected without a pair");

endmodule

### rtl/netlist_char_tokenizer_unit.sv
// ============================================================================
// netlist_char_tokenizer_unit
// Streaming lexer for structural netlists: one source byte in, lexeme
// characters and token-done results out.
// ============================================================================
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ---------------------------------
//  input    in         i_valid / o_ready     i_char_in, i_end_of_stream
//  result   out        o_valid / i_ready     o_kind, o_lexeme_char,
//                                            o_char_valid, o_token_done, o_error
//
//  One byte is taken per cycle; the front end lexes it in the cycle it is
//  accepted. Each byte gives zero, one or two results, and the back end sends
//  one result per cycle while i_ready is high, so a byte that closes a token
//  and starts another costs two output results. A four-entry queue decouples
//  the two sides; input stalls only when it is full. Reset (synchronous,
//  active low) returns the lexer to idle and empties the queue; after an
//  error the lexer stays halted until reset.
//
module netlist_char_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_kind,
    output logic [7:0]  o_lexeme_char,
    output logic        o_char_valid,
    output logic        o_token_done,
    output logic [1:0]  o_error
);

    logic               q_push, q_pop, q_empty, q_full;
    ntok_pkg::t_entry   q_wdata, q_rdata;

    // lexer front end
    ntok_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_char_in       (i_char_in),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (q_full),
        .o_ready         (o_ready),
        .o_push          (q_push),
        .o_entry         (q_wdata)
    );

    // result queue
    ntok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wdata),
        .i_pop   (q_pop),
        .o_entry (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // output back end
    ntok_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_entry       (q_rdata),
        .o_pop         (q_pop),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_lexeme_char (o_lexeme_char),
        .o_char_valid  (o_char_valid),
        .o_token_done  (o_token_done),
        .o_error       (o_error)
    );

endmodule
